### rtl/latency_histogram_monitor_unit_defines.svh
// ----------------------------------------------------------------------------
// Latency histogram monitor assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LATENCY_HISTOGRAM_MONITOR_UNIT_DEFINES_SVH
`define LATENCY_HISTOGRAM_MONITOR_UNIT_DEFINES_SVH

`ifndef SYNTH
// check with reset masking
`define LHM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds through reset
`define LHM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LHM_ASSERT(lbl, clk, rst, prop, msg)
`define LHM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/lhm_pkg.sv
// ----------------------------------------------------------------------------
// Latency histogram monitor package
// Field widths, bus layouts and the fixed histogram bin bounds.
// ----------------------------------------------------------------------------
package lhm_pkg;

   localparam int NUM_BINS  = 16;
   localparam int BIN_IDX_W = $clog2(NUM_BINS);

   localparam int CNT_W = 32;
   localparam int SUM_W = 64;

   // request tdata: latency_us, is_error, byte_count, is_short
   localparam int REQ_BITS = CNT_W + 1 + CNT_W + 1;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;

   // response tdata: bin_index .. overflow_seen
   localparam int RSP_BITS = BIN_IDX_W + 5 * CNT_W + 2 * SUM_W + 1;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [SUM_W-1:0] sum_type;
   typedef logic [BIN_IDX_W-1:0] bin_idx_type;

   // upper bounds of the bins; the last one catches everything
   localparam cnt_type BIN_BOUND [NUM_BINS] = '{
      32'd4,    32'd16,   32'd64,    32'd128,
      32'd256,  32'd512,  32'd1024,  32'd2048,
      32'd2903, 32'd4096, 32'd5805,  32'd8192,
      32'd10000, 32'd20000, 32'd100000, 32'hFFFF_FFFF
   };

   // first bin whose bound is not below the latency
   function automatic bin_idx_type find_bin(input cnt_type lat);
      bin_idx_type idx;
      idx = bin_idx_type'(NUM_BINS - 1);
      for (int i = NUM_BINS - 2; i >= 0; i--) begin
         if (lat <= BIN_BOUND[i]) begin
            idx = bin_idx_type'(i);
         end
      end
      return idx;
   endfunction

endpackage

### rtl/latency_histogram_monitor_unit.sv
// ----------------------------------------------------------------------------
// Latency histogram monitor
// Saturating operation statistics with a 16-bin latency histogram.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation record per transfer (latency, error flag,
//   byte count, short-read flag). rsp_* returns one record per request with
//   the updated bin count, totals, peak latency and sticky overflow flag.
//   Pipeline: bin lookup and memory read into the stage 1 registers, then
//   update into the output register.
//   Throughput: 1 request per cycle while rsp_tready is high, set by the
//   read-modify-write of the bin counter memory; a write forwarding
//   register covers a read of the bin written in the same cycle.
//   Reset: all counters, totals, peak and overflow flag clear; per-bin valid
//   bits make unwritten histogram entries read as zero, no clearing pass.
//   Stall: when rsp_tready is low the output register holds, the update
//   stage holds behind it and req_tready drops once both are full.
// ----------------------------------------------------------------------------
`include "latency_histogram_monitor_unit_defines.svh"

module latency_histogram_monitor_unit
   import lhm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   // [31:0] latency_us, [32] is_error, [64:33] byte_count, [65] is_short
   input  logic [REQ_W-1:0] req_tdata,
   // response channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [3:0] bin_index, [35:4] bin_total, [67:36] event_total,
   // [131:68] latency_sum, [163:132] latency_peak, [195:164] error_total,
   // [227:196] short_total, [291:228] byte_sum, [292] overflow_seen
   output logic [RSP_W-1:0] rsp_tdata
);

   // request field unpack
   cnt_type     req_lat;
   logic        req_err;
   cnt_type     req_bytes;
   logic        req_short;
   bin_idx_type req_bin;

   assign req_lat   = req_tdata[CNT_W-1:0];
   assign req_err   = req_tdata[CNT_W];
   assign req_bytes = req_tdata[2*CNT_W:CNT_W+1];
   assign req_short = req_tdata[2*CNT_W+1];
   assign req_bin   = find_bin(req_lat);

   // pipeline control
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic s1_adv;
   logic req_xfer;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // histogram memory and per-bin valid bits
   cnt_type              bin_mem [NUM_BINS];
   logic [NUM_BINS-1:0]  bin_vld_ff;
   cnt_type              rd_data_ff;
   logic                 rd_vld_ff;

   // stage 1 payload
   cnt_type     s1_lat_ff;
   logic        s1_err_ff;
   cnt_type     s1_bytes_ff;
   logic        s1_short_ff;
   bin_idx_type s1_bin_ff;

   // last write, forwarded to a read of the same bin
   logic        wr_valid_ff;
   bin_idx_type wr_bin_ff;
   cnt_type     wr_data_ff;

   // scalar state
   cnt_type event_ff;
   sum_type lat_sum_ff;
   cnt_type peak_ff;
   cnt_type err_ff;
   cnt_type short_ff;
   sum_type byte_sum_ff;
   logic    sat_ff;

   // next values
   cnt_type bin_cur;
   cnt_type bin_in;
   cnt_type event_in;
   sum_type lat_sum_in;
   cnt_type peak_in;
   cnt_type err_in;
   cnt_type short_in;
   sum_type byte_sum_in;
   logic    sat_in;
   logic [SUM_W:0] lat_add;
   logic [SUM_W:0] byte_add;

   // memory read on request transfer, write on update
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rd_data_ff <= bin_mem[req_bin];
      end
      if (s1_adv) begin
         bin_mem[s1_bin_ff] <= bin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (req_xfer) begin
            rd_vld_ff <= bin_vld_ff[req_bin];
         end
         if (s1_adv) begin
            bin_vld_ff[s1_bin_ff] <= 1'b1;
         end
      end
   end

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_lat_ff   <= req_lat;
         s1_err_ff   <= req_err;
         s1_bytes_ff <= req_bytes;
         s1_short_ff <= req_short;
         s1_bin_ff   <= req_bin;
      end
   end

   // update arithmetic
   always_comb begin
      if (wr_valid_ff && (wr_bin_ff == s1_bin_ff)) begin
         bin_cur = wr_data_ff;
      end else if (rd_vld_ff) begin
         bin_cur = rd_data_ff;
      end else begin
         bin_cur = '0;
      end

      sat_in = sat_ff;

      bin_in = bin_cur + cnt_type'(1);
      if (&bin_cur) begin
         bin_in = bin_cur;
         sat_in = 1'b1;
      end

      event_in = event_ff + cnt_type'(1);
      if (&event_ff) begin
         event_in = event_ff;
         sat_in   = 1'b1;
      end

      err_in = err_ff;
      if (s1_err_ff) begin
         err_in = err_ff + cnt_type'(1);
         if (&err_ff) begin
            err_in = err_ff;
            sat_in = 1'b1;
         end
      end

      short_in = short_ff;
      if (s1_short_ff) begin
         short_in = short_ff + cnt_type'(1);
         if (&short_ff) begin
            short_in = short_ff;
            sat_in   = 1'b1;
         end
      end

      lat_add    = {1'b0, lat_sum_ff} + {{(SUM_W-CNT_W+1){1'b0}}, s1_lat_ff};
      lat_sum_in = lat_add[SUM_W-1:0];
      if (lat_add[SUM_W]) begin
         lat_sum_in = '1;
         sat_in     = 1'b1;
      end

      byte_add    = {1'b0, byte_sum_ff} + {{(SUM_W-CNT_W+1){1'b0}}, s1_bytes_ff};
      byte_sum_in = byte_add[SUM_W-1:0];
      if (byte_add[SUM_W]) begin
         byte_sum_in = '1;
         sat_in      = 1'b1;
      end

      peak_in = (s1_lat_ff > peak_ff) ? s1_lat_ff : peak_ff;
   end

   // state commit
   always_ff @(posedge clock) begin
      if (reset) begin
         event_ff    <= '0;
         lat_sum_ff  <= '0;
         peak_ff     <= '0;
         err_ff      <= '0;
         short_ff    <= '0;
         byte_sum_ff <= '0;
         sat_ff      <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         event_ff    <= event_in;
         lat_sum_ff  <= lat_sum_in;
         peak_ff     <= peak_in;
         err_ff      <= err_in;
         short_ff    <= short_in;
         byte_sum_ff <= byte_sum_in;
         sat_ff      <= sat_in;
         wr_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         wr_bin_ff  <= s1_bin_ff;
         wr_data_ff <= bin_in;
      end
   end

   // output register
   logic [RSP_W-1:0] rsp_tdata_ff;
   logic [RSP_W-1:0] rsp_tdata_in;

   always_comb begin
      rsp_tdata_in = {
         {(RSP_W-RSP_BITS){1'b0}},
         sat_in, byte_sum_in, short_in, err_in, peak_in,
         lat_sum_in, event_in, bin_in, s1_bin_ff
      };
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tdata = rsp_tdata_ff;

   // checks
   `LHM_ASSERT(a_s1_hold, clock, reset, !req_tready |=> s1_valid_ff, "stalled item dropped")
   `LHM_ASSERT(a_s1_data, clock, reset, !req_tready |=> $stable(s1_bin_ff), "item changed")
   `LHM_ASSERT(a_event_nonzero, clock, reset, s1_adv |=> (event_ff != '0), "event count zero")
   `LHM_ASSERT(a_sat_sticky, clock, reset, sat_ff |=> sat_ff, "overflow flag cleared")
   `LHM_ASSERT(a_peak_covers, clock, reset, s1_adv |=> (peak_ff >= $past(s1_lat_ff)), "peak low")

endmodule

### test/latency_histogram_monitor_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency histogram monitor testbench
// Sends operation records over the request stream and checks every statistics
// record on the response stream against a local model of the counters, the
// 64-bit totals, the peak latency and the 16-bin histogram. A directed set of
// bin edges and field extremes comes first, then random records in three
// flow-control phases: receiver stalling, sender idling, and full rate.
// ----------------------------------------------------------------------------
module latency_histogram_monitor_unit_tb;
   import lhm_pkg::*;

   localparam int LAST_BIN = 15;

   // bin upper bounds, kept locally for the model
   localparam cnt_type LAT_LIMIT [16] = '{
      32'd4,     32'd16,    32'd64,     32'd128,
      32'd256,   32'd512,   32'd1024,   32'd2048,
      32'd2903,  32'd4096,  32'd5805,   32'd8192,
      32'd10000, 32'd20000, 32'd100000, 32'hFFFF_FFFF
   };

   // one operation record; hold_off makes the sender wait for an empty pipe
   typedef struct {
      cnt_type latency_us;
      logic    is_error;
      cnt_type byte_count;
      logic    is_short;
      logic    hold_off;
   } op_rec_type;

   // one statistics record as returned by the block
   typedef struct {
      bin_idx_type bin_index;
      cnt_type     bin_total;
      cnt_type     event_total;
      sum_type     latency_sum;
      cnt_type     latency_peak;
      cnt_type     error_total;
      cnt_type     short_total;
      sum_type     byte_sum;
      logic        overflow_seen;
   } stats_rec_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   op_rec_type    op_pending [$];
   stats_rec_type stats_expected [$];

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_idle_pct = 0;
   int          fail_count = 0;
   int          ops_sent = 0;
   int          stats_checked = 0;
   int          hold_offs = 0;

   // model state
   cnt_type event_cnt = '0;
   sum_type lat_acc = '0;
   cnt_type lat_max = '0;
   cnt_type err_cnt = '0;
   cnt_type short_cnt = '0;
   sum_type byte_acc = '0;
   cnt_type bin_cnt [16] = '{default: '0};
   logic    saturated = 1'b0;

   latency_histogram_monitor_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // saturating 32-bit increment
   function automatic cnt_type sat_inc(input cnt_type v);
      if (v == '1) begin
         saturated = 1'b1;
         return v;
      end
      return v + cnt_type'(1);
   endfunction

   // saturating 64-bit accumulate
   function automatic sum_type sat_add(input sum_type v, input cnt_type a);
      if (sum_type'(a) > ~v) begin
         saturated = 1'b1;
         return '1;
      end
      return v + sum_type'(a);
   endfunction

   // update the model with one accepted operation and queue its statistics
   task automatic record_operation(input op_rec_type op);
      stats_rec_type s;
      bin_idx_type   b;
      event_cnt = sat_inc(event_cnt);
      lat_acc = sat_add(lat_acc, op.latency_us);
      if (op.latency_us > lat_max) begin
         lat_max = op.latency_us;
      end
      if (op.is_error) begin
         err_cnt = sat_inc(err_cnt);
      end
      if (op.is_short) begin
         short_cnt = sat_inc(short_cnt);
      end
      byte_acc = sat_add(byte_acc, op.byte_count);
      // first bin whose bound is not below the latency
      b = '0;
      while (b < LAST_BIN && op.latency_us > LAT_LIMIT[b]) begin
         b++;
      end
      bin_cnt[b] = sat_inc(bin_cnt[b]);
      s.bin_index     = b;
      s.bin_total     = bin_cnt[b];
      s.event_total   = event_cnt;
      s.latency_sum   = lat_acc;
      s.latency_peak  = lat_max;
      s.error_total   = err_cnt;
      s.short_total   = short_cnt;
      s.byte_sum      = byte_acc;
      s.overflow_seen = saturated;
      stats_expected.push_back(s);
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // compare one received statistics record with the oldest expectation
   task automatic check_stats(input logic [RSP_W-1:0] d);
      stats_rec_type want;
      if (stats_expected.size() == 0) begin
         $error("statistics record 0x%0h arrived with none expected", d);
         fail_count++;
      end else begin
         want = stats_expected.pop_front();
         check_field("bin_index", 64'(want.bin_index), 64'(d[3:0]));
         check_field("bin_total", 64'(want.bin_total), 64'(d[35:4]));
         check_field("event_total", 64'(want.event_total), 64'(d[67:36]));
         check_field("latency_sum", want.latency_sum, d[131:68]);
         check_field("latency_peak", 64'(want.latency_peak), 64'(d[163:132]));
         check_field("error_total", 64'(want.error_total), 64'(d[195:164]));
         check_field("short_total", 64'(want.short_total), 64'(d[227:196]));
         check_field("byte_sum", want.byte_sum, d[291:228]);
         check_field("overflow_seen", 64'(want.overflow_seen), 64'(d[292]));
         stats_checked++;
      end
   endtask

   // request driver: holds an offered transfer until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            record_operation(op_pending.pop_front());
            ops_sent++;
         end
         if (req_tvalid && !req_tready) begin
            // keep offering the same record
         end else if (op_pending.size() != 0 &&
                      !(op_pending[0].hold_off && stats_expected.size() != 0) &&
                      $urandom_range(99) >= sender_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_W'({op_pending[0].is_short, op_pending[0].byte_count,
                                  op_pending[0].is_error, op_pending[0].latency_us});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_stats(rsp_tdata);
         end
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic queue_op(input cnt_type lat, input logic err, input cnt_type bytes,
                           input logic shrt, input logic hold);
      op_rec_type op;
      op.latency_us = lat;
      op.is_error   = err;
      op.byte_count = bytes;
      op.is_short   = shrt;
      op.hold_off   = hold;
      op_pending.push_back(op);
      if (hold) begin
         hold_offs++;
      end
   endtask

   // latency spread over the bins, with bound edges and raw 32-bit values
   function automatic cnt_type pick_latency();
      bin_idx_type b;
      int unsigned r;
      cnt_type     lo;
      b = bin_idx_type'($urandom_range(LAST_BIN));
      r = $urandom_range(9);
      lo = (b == 0) ? '0 : LAT_LIMIT[b - bin_idx_type'(1)] + cnt_type'(1);
      if (r < 6) begin
         return $urandom_range(LAT_LIMIT[b], lo);
      end else if (r < 8) begin
         return LAT_LIMIT[b] + cnt_type'($urandom_range(2)) - cnt_type'(1);
      end
      return $urandom;
   endfunction

   function automatic cnt_type pick_bytes();
      int unsigned r;
      r = $urandom_range(9);
      if (r < 4) begin
         return $urandom_range(4096);
      end else if (r < 8) begin
         return $urandom;
      end else if (r == 8) begin
         return '1;
      end
      return '0;
   endfunction

   task automatic run_random_phase(input int unsigned count);
      int unsigned hold_at;
      hold_at = $urandom_range(count - 1, count / 4);
      for (int unsigned i = 0; i < count; i++) begin
         queue_op(pick_latency(), 1'($urandom_range(1)), pick_bytes(),
                  1'($urandom_range(1)), i == hold_at);
      end
      while (op_pending.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // stimulus sequencing
   initial begin
      int bins_hit;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: zero, bin edges, largest latencies, byte and flag extremes
      queue_op(32'd0, 1'b0, 32'd0, 1'b0, 1'b0);
      queue_op(32'd1, 1'b1, 32'd1, 1'b1, 1'b0);
      queue_op(32'd4, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0);
      queue_op(32'd5, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0);
      queue_op(32'd16, 1'b0, 32'h8000_0000, 1'b1, 1'b0);
      queue_op(32'd17, 1'b0, 32'h7FFF_FFFF, 1'b1, 1'b0);
      queue_op(32'd2903, 1'b1, 32'd512, 1'b1, 1'b0);
      queue_op(32'd2904, 1'b0, 32'h5555_5555, 1'b0, 1'b0);
      queue_op(32'd100000, 1'b1, 32'hAAAA_AAAA, 1'b0, 1'b0);
      queue_op(32'd100001, 1'b0, 32'd0, 1'b1, 1'b0);
      queue_op(32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0);
      queue_op(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0);
      queue_op(32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1, 1'b1);
      queue_op(32'd3, 1'b0, 32'd7, 1'b0, 1'b0);
      queue_op(32'h8000_0000, 1'b0, 32'd4096, 1'b1, 1'b0);
      queue_op(32'd20000, 1'b1, 32'd100, 1'b0, 1'b0);
      while (op_pending.size() != 0) begin
         @(posedge clock);
      end

      // random records under three flow-control regimes
      sender_idle_pct = 8;
      receiver_idle_pct = 85;
      run_random_phase(167);
      sender_idle_pct = 85;
      receiver_idle_pct = 8;
      run_random_phase(167);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      run_random_phase(166);

      // drain and let the pipeline settle
      while (stats_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      bins_hit = 0;
      for (int i = 0; i <= LAST_BIN; i++) begin
         if (bin_cnt[i] != 0) begin
            bins_hit++;
         end
      end
      $display("Covered %0d operation records and %0d statistics records, %0d hold-offs.",
               ops_sent, stats_checked, hold_offs);
      $display("Histogram bins reached: %0d of 16; mismatches: %0d.", bins_hit, fail_count);
      if (fail_count == 0) begin
         $display("latency_histogram_monitor_unit_tb OK");
      end else begin
         $display("latency_histogram_monitor_unit_tb NOT OK");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("latency_histogram_monitor_unit_tb NOT OK");
      $finish;
   end

endmodule
